// ----- src/srq_pkg.sv -----
package srq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CAP_W = 5;
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic [7:0] NO_TASK = 8'd255;

  // Operation codes
  localparam logic [1:0] OP_ENQUEUE = 2'd0;
  localparam logic [1:0] OP_DEQUEUE = 2'd1;
  localparam logic [1:0] OP_PEEK    = 2'd2;

  // Status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;

  // Register indexes
  localparam logic [1:0] REG_ORDER_MODE = 2'd0;
  localparam logic [1:0] REG_CAPACITY   = 2'd1;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  task_id;
    logic [7:0]  task_priority;
    logic [15:0] task_period;
    logic [15:0] task_cost;
  } cmd_t;

  typedef struct packed {
    logic [7:0] head_task;
    logic [1:0] status;
  } result_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [7:0]  prio;
    logic [15:0] period;
    logic [15:0] cost;
  } entry_t;

  // Entry travelling down the chain during an insertion
  typedef struct packed {
    logic   vld;
    logic   shift;
    entry_t entry;
  } carry_t;

endpackage

// ----- src/sorted_ready_queue.sv -----
// Sorted ready queue: a chain of cells holding task entries in rank order,
// cell 0 at the head.
// Command channel: a transfer happens when start is high and busy is low;
// cmd carries the operation and the task id and keys.
// Result channel: done pulses for one cycle with result (head task and
// status); the receiver cannot stall, so every result is taken at once.
// Configuration channel: cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high. Index 0 sets the order mode, index 1 sets the
// capacity and empties the queue; other indexes are ignored.
// Timing: dequeue, peek, dropped enqueue and unknown operations give done in
// the cycle after the transfer. An accepted enqueue walks one cell per cycle
// until it reaches the first free cell, as the carry ripples through the cell
// chain, and done follows once that cell takes the entry. busy stays high
// during the walk.
// Throughput: after any other command the next transfer can follow on the
// next cycle; an accepted enqueue holds busy until a free cell takes the entry.
// Reset: queue empty, order mode priority, capacity 16.
module sorted_ready_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  srq_pkg::cmd_t     cmd,
  output logic              done,
  output srq_pkg::result_t  result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [4:0]        cfg_data
);
  import srq_pkg::*;

  localparam logic S_IDLE   = 1'b0;
  localparam logic S_INSERT = 1'b1;

  logic             state;
  logic             order_mode;
  logic [CAP_W-1:0] capacity;
  logic [CNT_W-1:0] count;
  carry_t           inject;

  logic [CMP_W-1:0] cap_ext;
  logic [CMP_W-1:0] cap_eff;
  logic [CMP_W-1:0] count_ext;
  logic             accept;
  logic             cfg_write;
  logic             clear;
  logic             full;
  logic             empty;
  logic             shift_left;
  logic             absorbed;

  logic   [QUEUE_DEPTH-1:0] cell_valid;
  logic   [QUEUE_DEPTH-1:0] cell_absorb;
  entry_t                   cell_entry [QUEUE_DEPTH];
  carry_t                   carry      [QUEUE_DEPTH+1];

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign clear     = cfg_write && (cfg_index == REG_CAPACITY);

  assign busy   = (state == S_INSERT);
  assign accept = start && !busy;

  // Clamp capacity to 1 .. QUEUE_DEPTH
  always_comb begin
    cap_ext   = CMP_W'(capacity);
    count_ext = CMP_W'(count);
    if (cap_ext == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_ext > CMP_W'(QUEUE_DEPTH)) begin
      cap_eff = CMP_W'(QUEUE_DEPTH);
    end else begin
      cap_eff = cap_ext;
    end
  end

  assign full       = count_ext >= cap_eff;
  assign empty      = (count == '0);
  assign shift_left = accept && (cmd.mode == OP_DEQUEUE) && !empty;
  assign absorbed   = |cell_absorb;

  // Cell 0 takes the new task from the inject register
  assign carry[0] = inject;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic   right_valid;
    entry_t right_entry;
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_valid = 1'b0;
      assign right_entry = cell_entry[i];
    end else begin : g_mid
      assign right_valid = cell_valid[i+1];
      assign right_entry = cell_entry[i+1];
    end
    srq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .clear       (clear),
      .order_mode  (order_mode),
      .shift_left  (shift_left),
      .right_valid (right_valid),
      .right_entry (right_entry),
      .carry_in    (carry[i]),
      .valid       (cell_valid[i]),
      .entry       (cell_entry[i]),
      .carry_out   (carry[i+1]),
      .absorb      (cell_absorb[i])
    );
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      order_mode <= 1'b0;
      capacity   <= 5'd16;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ORDER_MODE: order_mode <= cfg_data[0];
        REG_CAPACITY:   capacity   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Control: accept commands, launch insertions, count entries, report
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      inject.vld <= 1'b0;
      done       <= 1'b0;
    end else begin
      inject.vld <= 1'b0;
      done       <= 1'b0;
      if (clear) begin
        count <= '0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            result.head_task <= NO_TASK;
            result.status    <= ST_DONE;
            case (cmd.mode)
              OP_ENQUEUE: begin
                if (full) begin
                  result.status <= ST_FULL;
                  done          <= 1'b1;
                end else begin
                  inject.vld          <= 1'b1;
                  inject.shift        <= 1'b0;
                  inject.entry.id     <= cmd.task_id;
                  inject.entry.prio   <= cmd.task_priority;
                  inject.entry.period <= cmd.task_period;
                  inject.entry.cost   <= cmd.task_cost;
                  state               <= S_INSERT;
                end
              end
              OP_DEQUEUE, OP_PEEK: begin
                done <= 1'b1;
                if (empty) begin
                  result.status <= ST_EMPTY;
                end else begin
                  result.head_task <= cell_entry[0].id;
                  if (cmd.mode == OP_DEQUEUE) begin
                    count <= count - CNT_W'(1);
                  end
                end
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_INSERT: begin
          // Hold until a free cell takes the carried entry
          if (absorbed) begin
            count <= count + CNT_W'(1);
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- src/srq_cell.sv -----
module srq_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           clear,
  input  logic           order_mode,
  input  logic           shift_left,
  input  logic           right_valid,
  input  srq_pkg::entry_t right_entry,
  input  srq_pkg::carry_t carry_in,
  output logic           valid,
  output srq_pkg::entry_t entry,
  output srq_pkg::carry_t carry_out,
  output logic           absorb
);
  import srq_pkg::*;

  logic behind;
  logic new_zero;

  // Stored entry ranks strictly behind the carried task?
  always_comb begin
    new_zero = (carry_in.entry.period == 16'd0) && (carry_in.entry.cost == 16'd0);
    if (!order_mode) begin
      behind = entry.prio > carry_in.entry.prio;
    end else begin
      behind = !new_zero &&
               ((entry.period > carry_in.entry.period) ||
                ((entry.period == carry_in.entry.period) &&
                 (entry.cost > carry_in.entry.cost)));
    end
  end

  assign absorb = carry_in.vld && !valid;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid         <= 1'b0;
      carry_out.vld <= 1'b0;
    end else if (shift_left) begin
      valid         <= right_valid;
      entry         <= right_entry;
      carry_out.vld <= 1'b0;
    end else if (carry_in.vld) begin
      if (!valid) begin
        valid         <= 1'b1;
        entry         <= carry_in.entry;
        carry_out.vld <= 1'b0;
      end else if (carry_in.shift || behind) begin
        entry           <= carry_in.entry;
        carry_out.vld   <= 1'b1;
        carry_out.shift <= 1'b1;
        carry_out.entry <= entry;
      end else begin
        carry_out.vld   <= 1'b1;
        carry_out.shift <= 1'b0;
        carry_out.entry <= carry_in.entry;
      end
    end else begin
      carry_out.vld <= 1'b0;
    end
  end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import srq_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int N_PHASES = 9;
  localparam int PHASE_ITEMS = 150;
  localparam int N_PLAN = 31;

  // Codes the package does not name
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [1:0] REG_VACANT = 2'd2;
  localparam logic [1:0] REG_SPARE = 2'd3;

  typedef enum logic {ROW_CMD, ROW_REG} row_kind_e;

  // One line of the directed plan: a command or a register write.
  // When chk is set, want is the known answer; otherwise the model decides.
  typedef struct packed {
    row_kind_e  kind;
    cmd_t       c;
    logic [1:0] ridx;
    logic [4:0] rval;
    logic       chk;
    result_t    want;
  } row_t;

  localparam row_t DIRECTED_PLAN [N_PLAN] = '{
    // empty queue after reset, unused operation
    '{ROW_CMD, '{OP_DEQUEUE, 8'd0, 8'd0, 16'd0, 16'd0}, '0, '0, 1'b1, '{NO_TASK, ST_EMPTY}},
    '{ROW_CMD, '{OP_PEEK, 8'd0, 8'd0, 16'd0, 16'd0}, '0, '0, 1'b1, '{NO_TASK, ST_EMPTY}},
    '{ROW_CMD, '{OP_UNUSED, 8'd7, 8'd1, 16'd1, 16'd1}, '0, '0, 1'b1, '{NO_TASK, ST_DONE}},
    // priority order, equal keys keep arrival order, id 255 stored as given
    '{ROW_CMD, '{OP_ENQUEUE, 8'd10, 8'd200, 16'd100, 16'd5}, '0, '0, 1'b1,
      '{NO_TASK, ST_DONE}},
    '{ROW_CMD, '{OP_ENQUEUE, 8'd0, 8'd0, 16'd0, 16'd0}, '0, '0, 1'b1, '{NO_TASK, ST_DONE}},
    '{ROW_CMD, '{OP_ENQUEUE, 8'd254, 8'd0, 16'd9, 16'd9}, '0, '0, 1'b1, '{NO_TASK, ST_DONE}},
    '{ROW_CMD, '{OP_ENQUEUE, 8'd255, 8'd255, 16'd65535, 16'd65535}, '0, '0, 1'b1,
      '{NO_TASK, ST_DONE}},
    '{ROW_CMD, '{OP_PEEK, 8'd0, 8'd0, 16'd0, 16'd0}, '0, '0, 1'b0, '0},
    // switch to period order with entries still queued; zero keys go last
    '{ROW_REG, '0, REG_ORDER_MODE, 5'd1, 1'b0, '0},
    '{ROW_CMD, '{OP_ENQUEUE, 8'd20, 8'd0, 16'd0, 16'd0}, '0, '0, 1'b1, '{NO_TASK, ST_DONE}},
    '{ROW_CMD, '{OP_DEQUEUE, 8'd0, 8'd0, 16'd0, 16'd0}, '0, '0, 1'b0, '0},
    '{ROW_CMD, '{OP_DEQUEUE, 8'd0, 8'd0, 16'd0, 16'd0}, '0, '0, 1'b0, '0},
    '{ROW_CMD, '{OP_DEQUEUE, 8'd0, 8'd0, 16'd0, 16'd0}, '0, '0, 1'b0, '0},
    '{ROW_CMD, '{OP_DEQUEUE, 8'd0, 8'd0, 16'd0, 16'd0}, '0, '0, 1'b0, '0},
    '{ROW_CMD, '{OP_DEQUEUE, 8'd0, 8'd0, 16'd0, 16'd0}, '0, '0, 1'b0, '0},
    '{ROW_CMD, '{OP_DEQUEUE, 8'd0, 8'd0, 16'd0, 16'd0}, '0, '0, 1'b1, '{NO_TASK, ST_EMPTY}},
    // capacity 0 behaves as a single slot
    '{ROW_REG, '0, REG_CAPACITY, 5'd0, 1'b0, '0},
    '{ROW_CMD, '{OP_ENQUEUE, 8'd1, 8'd3, 16'd3, 16'd3}, '0, '0, 1'b1, '{NO_TASK, ST_DONE}},
    '{ROW_CMD, '{OP_ENQUEUE, 8'd2, 8'd0, 16'd0, 16'd1}, '0, '0, 1'b1, '{NO_TASK, ST_FULL}},
    '{ROW_CMD, '{OP_DEQUEUE, 8'd0, 8'd0, 16'd0, 16'd0}, '0, '0, 1'b0, '0},
    // small ring in period order, period and cost extremes, full drop
    '{ROW_REG, '0, REG_CAPACITY, 5'd3, 1'b0, '0},
    '{ROW_CMD, '{OP_ENQUEUE, 8'd3, 8'd9, 16'd0, 16'd0}, '0, '0, 1'b1, '{NO_TASK, ST_DONE}},
    '{ROW_CMD, '{OP_ENQUEUE, 8'd4, 8'd9, 16'd65535, 16'd0}, '0, '0, 1'b1,
      '{NO_TASK, ST_DONE}},
    '{ROW_CMD, '{OP_ENQUEUE, 8'd5, 8'd9, 16'd65535, 16'd65535}, '0, '0, 1'b1,
      '{NO_TASK, ST_DONE}},
    '{ROW_CMD, '{OP_ENQUEUE, 8'd6, 8'd0, 16'd1, 16'd0}, '0, '0, 1'b1, '{NO_TASK, ST_FULL}},
    '{ROW_CMD, '{OP_DEQUEUE, 8'd0, 8'd0, 16'd0, 16'd0}, '0, '0, 1'b0, '0},
    '{ROW_CMD, '{OP_DEQUEUE, 8'd0, 8'd0, 16'd0, 16'd0}, '0, '0, 1'b0, '0},
    '{ROW_CMD, '{OP_DEQUEUE, 8'd0, 8'd0, 16'd0, 16'd0}, '0, '0, 1'b0, '0},
    // an unknown index is ignored; capacity above the depth clamps to it
    '{ROW_REG, '0, REG_SPARE, 5'd31, 1'b0, '0},
    '{ROW_REG, '0, REG_CAPACITY, 5'd31, 1'b0, '0},
    '{ROW_REG, '0, REG_ORDER_MODE, 5'd0, 1'b0, '0}
  };

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  cmd_t       cmd;
  logic       done;
  result_t    result;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [4:0] cfg_data;

  sorted_ready_queue u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the ready queue
  entry_t      rq_slot [QUEUE_DEPTH];
  int unsigned rq_head;
  int unsigned rq_tail;
  int unsigned rq_count;
  logic        rq_by_period;
  logic [4:0]  rq_cap_reg;

  result_t awaited_results [$];
  int      errors;
  int      n_cmds;
  int      n_full;
  int      n_empty;
  int      n_reg_writes;
  int      quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void clear_queue();
    for (int i = 0; i < QUEUE_DEPTH; i++) rq_slot[i].id = NO_TASK;
    rq_head = 0;
    rq_tail = 0;
    rq_count = 0;
  endfunction

  // True when the stored entry must sit behind the new task
  function automatic bit ranks_after(entry_t e, cmd_t c);
    if (!rq_by_period) return e.prio > c.task_priority;
    if (c.task_period == 16'd0 && c.task_cost == 16'd0) return 1'b0;
    return e.period > c.task_period ||
           (e.period == c.task_period && e.cost > c.task_cost);
  endfunction

  // Apply one command to the shadow queue and return the head/status it gives
  function automatic result_t ready_queue_op(cmd_t c);
    int unsigned cap;
    int unsigned pos;
    int unsigned k;
    result_t     r;
    cap = (rq_cap_reg == 5'd0) ? 1 :
          (rq_cap_reg > QUEUE_DEPTH) ? QUEUE_DEPTH : int'(rq_cap_reg);
    r.head_task = NO_TASK;
    r.status = ST_DONE;
    rq_head = rq_head % cap;
    rq_tail = rq_tail % cap;
    case (c.mode)
      OP_ENQUEUE: begin
        if (rq_count >= cap) begin
          r.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < rq_count && !ranks_after(rq_slot[(rq_head + pos) % cap], c)) pos++;
          // shift the tail end down one slot to open the gap
          for (k = rq_count; k > pos; k--)
            rq_slot[(rq_head + k) % cap] = rq_slot[(rq_head + k - 1) % cap];
          rq_slot[(rq_head + pos) % cap] =
            '{c.task_id, c.task_priority, c.task_period, c.task_cost};
          rq_tail = (rq_tail + 1) % cap;
          rq_count++;
        end
      end
      OP_DEQUEUE, OP_PEEK: begin
        if (rq_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.head_task = rq_slot[rq_head].id;
          if (c.mode == OP_DEQUEUE) begin
            rq_head = (rq_head + 1) % cap;
            rq_count--;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Present one command and hold it until the block takes it
  task automatic issue(input cmd_t c, input bit typed, input result_t want);
    result_t predicted;
    @(negedge clk);
    start = 1'b1;
    cmd = c;
    do @(posedge clk); while (busy);
    predicted = ready_queue_op(c);
    if (typed) predicted = want;
    awaited_results.push_back(predicted);
    n_cmds++;
    if (predicted.status == ST_FULL) n_full++;
    if (predicted.status == ST_EMPTY) n_empty++;
  endtask

  // Drop start, put garbage on the command bus and let the sender rest
  task automatic rest(input int cycles);
    @(negedge clk);
    start = 1'b0;
    cmd = cmd_t'({$urandom, $urandom});
    repeat (cycles) @(negedge clk);
  endtask

  // Hold off until every result is in and the block is idle
  task automatic settle();
    @(negedge clk);
    start = 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0 || busy);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [4:0] val);
    settle();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_ORDER_MODE) begin
      rq_by_period = val[0];
    end else if (idx == REG_CAPACITY) begin
      rq_cap_reg = val;
      clear_queue();
    end
    n_reg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Keys lean on zero, all ones and tiny values so ties and extremes are common
  function automatic logic [15:0] pick_key16();
    case ($urandom_range(0, 3))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 3));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_prio();
    case ($urandom_range(0, 3))
      0: return 8'd0;
      1: return 8'hFF;
      2: return 8'($urandom_range(0, 3));
      default: return 8'($urandom);
    endcase
  endfunction

  // Check every result against the oldest expectation
  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && done) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: result with nothing expected: head_task %0d status %0d",
                 $time, result.head_task, result.status);
        errors++;
      end else begin
        exp_r = awaited_results.pop_front();
        if (result.head_task !== exp_r.head_task) begin
          $display("%0t: head_task expected %0d actual %0d",
                   $time, exp_r.head_task, result.head_task);
          errors++;
        end
        if (result.status !== exp_r.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status, result.status);
          errors++;
        end
      end
    end
  end

  // Stop a hung run: count cycles in which no transfer of any kind happens
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    cmd_t       c;
    int         idle_pct;
    int         enq_pct;
    int         hold_at;
    int         sel;
    logic [4:0] cap_pick;

    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_ORDER_MODE;
    cfg_data = '0;
    errors = 0;
    n_cmds = 0;
    n_full = 0;
    n_empty = 0;
    n_reg_writes = 0;
    quiet_cycles = 0;
    rq_by_period = 1'b0;
    rq_cap_reg = 5'd16;
    for (int i = 0; i < QUEUE_DEPTH; i++) rq_slot[i] = '0;
    clear_queue();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed plan
    for (int r = 0; r < N_PLAN; r++) begin
      if (DIRECTED_PLAN[r].kind == ROW_REG) begin
        write_reg(DIRECTED_PLAN[r].ridx, DIRECTED_PLAN[r].rval);
      end else begin
        issue(DIRECTED_PLAN[r].c, DIRECTED_PLAN[r].chk, DIRECTED_PLAN[r].want);
      end
    end

    // Random phases: sender idles rarely, then often, then never
    for (int ph = 0; ph < N_PHASES; ph++) begin
      write_reg(REG_ORDER_MODE, {4'($urandom), ph[0]});
      // resize on even phases; odd phases keep the queued entries
      if (ph % 2 == 0) begin
        case (ph / 2)
          0: cap_pick = 5'd4;
          1: cap_pick = 5'd1;
          2: cap_pick = 5'd16;
          3: cap_pick = 5'd2;
          default: cap_pick = 5'($urandom_range(0, 31));
        endcase
        write_reg(REG_CAPACITY, cap_pick);
      end
      if (ph == 4) write_reg(REG_VACANT, 5'($urandom));
      idle_pct = (ph < 3) ? 18 : (ph < 6) ? 66 : 0;
      case ($urandom_range(0, 2))
        0: enq_pct = 35;
        1: enq_pct = 50;
        default: enq_pct = 70;
      endcase
      hold_at = $urandom_range(10, PHASE_ITEMS - 10);

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        sel = $urandom_range(0, 99);
        c.mode = (sel < enq_pct) ? OP_ENQUEUE :
                 (sel >= 98) ? OP_UNUSED :
                 ($urandom_range(0, 2) == 0) ? OP_PEEK : OP_DEQUEUE;
        c.task_id = 8'($urandom_range(0, 255));
        c.task_priority = pick_prio();
        c.task_period = pick_key16();
        c.task_cost = pick_key16();
        // let the pipeline run dry once per phase before the next transfer
        if (i == hold_at) settle();
        issue(c, 1'b0, '0);
        if ($urandom_range(0, 99) < idle_pct) rest($urandom_range(1, 4));
      end
    end

    @(negedge clk);
    start = 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (QUEUE_DEPTH + 2) @(posedge clk);

    $display("Ran %0d commands in %0d random phases plus a directed plan, %0d register writes",
             n_cmds, N_PHASES, n_reg_writes);
    $display("Saw %0d enqueues dropped on a full ring and %0d reads of an empty one",
             n_full, n_empty);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", errors);
      $display("status: fail");
    end
    $finish;
  end

endmodule
